### rtl/sm83_pkg.sv
// Shared types and constants of the SM83 subset execute core.
`default_nettype none
package sm83_pkg;
    localparam int MEM_DEPTH_DEF = 65536;

    localparam logic [1:0] ST_EXEC  = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;
    localparam logic [1:0] ST_STORE = 2'd3;

    localparam logic [7:0] FL_Z = 8'h80;
    localparam logic [7:0] FL_N = 8'h40;
    localparam logic [7:0] FL_H = 8'h20;
    localparam logic [7:0] FL_C = 8'h10;

    localparam logic [7:0] OP_HALT = 8'h76;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_OP,
        S_B1,
        S_B2,
        S_MRD,
        S_EXEC,
        S_WR2,
        S_DONE
    } state_t;

    // memory request from the sequencer
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;
endpackage
`default_nettype wire

### rtl/sm83_mem.sv
// Byte memory with one synchronous port and a clearing pass after reset.
`default_nettype none
module sm83_mem #(
    parameter int MEM_DEPTH = sm83_pkg::MEM_DEPTH_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  sm83_pkg::mem_req_t   req,
    output logic [7:0]           rdata,
    output logic                 clr_busy
);
    localparam int AW = $clog2(MEM_DEPTH);

    logic [7:0]  mem [MEM_DEPTH];
    logic [AW:0] clr_reg;
    logic [AW:0] clr_next;

    assign clr_busy = !clr_reg[AW];
    assign clr_next = clr_busy ? clr_reg + 1'b1 : clr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy) begin
            mem[clr_reg[AW-1:0]] <= 8'h00;
        end else if (req.wr) begin
            mem[req.addr[AW-1:0]] <= req.wdata;
        end
        rdata <= mem[req.addr[AW-1:0]];
    end
endmodule
`default_nettype wire

### rtl/sm83_seq.sv
// Instruction sequencer: fetch, operand reads, execute and write-back.
`default_nettype none
module sm83_seq (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire                   in_func,
    input  wire  [15:0]           in_addr,
    input  wire  [7:0]            in_data,
    input  wire                   clr_busy,
    input  wire  [7:0]            rdata,
    output sm83_pkg::mem_req_t    req,
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic [103:0]          out_data
);
    sm83_pkg::state_t st_reg, st_next;
    logic [15:0] pc_reg, af_reg, bc_reg, de_reg, hl_reg, sp_reg;
    logic [15:0] pc_next, af_next, bc_next, de_next, hl_next, sp_next;
    logic [7:0]  op_reg, op_next, b1_reg, b1_next, b2_reg, b2_next, m_reg, m_next;
    logic [4:0]  cyc_reg, cyc_next;
    logic [1:0]  stat_reg, stat_next;
    logic        ov_reg, ov_next;

    logic [2:0] y, z;
    logic [1:0] p;
    logic       q;
    logic [7:0] a, f;
    assign y = op_reg[5:3];
    assign z = op_reg[2:0];
    assign p = y[2:1];
    assign q = y[0];
    assign a = af_reg[15:8];
    assign f = af_reg[7:0];

    // decode source: in S_OP the opcode is still on the memory read data
    logic [7:0] op_dec;
    logic [2:0] dy, dz;
    logic [1:0] dp;
    logic       dq;
    assign op_dec = (st_reg == sm83_pkg::S_OP) ? rdata : op_reg;
    assign dy = op_dec[5:3];
    assign dz = op_dec[2:0];
    assign dp = dy[2:1];
    assign dq = dy[0];

    // operand needs of the fetched opcode
    logic need_b1, need_b2, need_m;
    logic [15:0] m_addr;
    always_comb begin
        need_b1 = 1'b0;
        need_b2 = 1'b0;
        need_m  = 1'b0;
        m_addr  = hl_reg;
        case (op_dec[7:6])
            2'd0: begin
                case (dz)
                    3'd0: begin
                        need_b1 = (dy == 3'd1) || (dy >= 3'd3);
                        need_b2 = (dy == 3'd1);
                    end
                    3'd1: begin
                        need_b1 = !dq;
                        need_b2 = !dq;
                    end
                    3'd2: begin
                        need_m = dq;
                        m_addr = (dp == 2'd0) ? bc_reg : (dp == 2'd1) ? de_reg : hl_reg;
                    end
                    3'd4, 3'd5: need_m = (dy == 3'd6);
                    3'd6: need_b1 = 1'b1;
                    default: ;
                endcase
            end
            2'd1: need_m = (dz == 3'd6) && (op_dec != sm83_pkg::OP_HALT);
            2'd2: need_m = (dz == 3'd6);
            default: ;
        endcase
    end

    function automatic logic [7:0] r8(input logic [2:0] i, input logic [15:0] bc,
                                      input logic [15:0] de, input logic [15:0] hl,
                                      input logic [7:0] av, input logic [7:0] mv);
        case (i)
            3'd0: r8 = bc[15:8];
            3'd1: r8 = bc[7:0];
            3'd2: r8 = de[15:8];
            3'd3: r8 = de[7:0];
            3'd4: r8 = hl[15:8];
            3'd5: r8 = hl[7:0];
            3'd6: r8 = mv;
            default: r8 = av;
        endcase
    endfunction

    // execute datapath
    logic [15:0] x_pc, x_af, x_bc, x_de, x_hl, x_sp;
    logic [4:0]  x_cyc;
    logic [1:0]  x_stat;
    logic        x_wr, x_wr2;
    logic [15:0] x_waddr;
    logic [7:0]  x_wdata;
    always_comb begin
        logic [7:0]  v, r, nf, b;
        logic [15:0] s, w, a16;
        logic [16:0] sum;
        logic [8:0]  t;
        logic [4:0]  tl;
        logic        c, cond;
        x_pc = pc_reg; x_bc = bc_reg; x_de = de_reg; x_hl = hl_reg; x_sp = sp_reg;
        x_af = af_reg; x_cyc = 5'd0; x_stat = sm83_pkg::ST_EXEC;
        x_wr = 1'b0; x_wr2 = 1'b0; x_waddr = hl_reg; x_wdata = 8'h00;
        v = 8'h00; r = 8'h00; nf = 8'h00; s = 16'h0; w = {b2_reg, b1_reg};
        a16 = w; sum = 17'h0; t = 9'h0; tl = 5'h0; c = 1'b0; cond = 1'b0;
        b = r8(z, bc_reg, de_reg, hl_reg, a, m_reg);
        case (op_reg[7:6])
            2'd0: begin
                case (z)
                    3'd0: begin
                        if (y == 3'd0) begin
                            x_pc = pc_reg + 16'd1; x_cyc = 5'd4;
                        end else if (y == 3'd1) begin
                            x_wr = 1'b1; x_wr2 = 1'b1; x_waddr = a16;
                            x_wdata = sp_reg[7:0];
                            x_pc = pc_reg + 16'd3; x_cyc = 5'd20;
                        end else if (y == 3'd2) begin
                            x_pc = pc_reg + 16'd2; x_cyc = 5'd4;
                        end else begin
                            case (y[1:0])
                                2'd0: cond = !f[7];
                                2'd1: cond = f[7];
                                2'd2: cond = !f[4];
                                default: cond = f[4];
                            endcase
                            if (y == 3'd3 || cond) begin
                                x_pc = pc_reg + 16'd2 + {{8{b1_reg[7]}}, b1_reg};
                                x_cyc = 5'd12;
                            end else begin
                                x_pc = pc_reg + 16'd2; x_cyc = 5'd8;
                            end
                        end
                    end
                    3'd1: begin
                        if (q) begin
                            case (p)
                                2'd0: s = bc_reg;
                                2'd1: s = de_reg;
                                2'd2: s = hl_reg;
                                default: s = sp_reg;
                            endcase
                            sum = {1'b0, hl_reg} + {1'b0, s};
                            nf = (f & sm83_pkg::FL_Z);
                            if ({1'b0, hl_reg[11:0]} + {1'b0, s[11:0]} > 13'h0FFF)
                                nf = nf | sm83_pkg::FL_H;
                            if (sum[16]) nf = nf | sm83_pkg::FL_C;
                            x_hl = sum[15:0];
                            x_af = {a, nf[7:4], 4'h0};
                            x_pc = pc_reg + 16'd1; x_cyc = 5'd8;
                        end else begin
                            case (p)
                                2'd0: x_bc = w;
                                2'd1: x_de = w;
                                2'd2: x_hl = w;
                                default: x_sp = w;
                            endcase
                            x_pc = pc_reg + 16'd3; x_cyc = 5'd12;
                        end
                    end
                    3'd2: begin
                        if (q) x_af = {m_reg, f};
                        else begin
                            x_wr = 1'b1; x_wdata = a;
                            x_waddr = (p == 2'd0) ? bc_reg : (p == 2'd1) ? de_reg : hl_reg;
                        end
                        if (p == 2'd2) x_hl = hl_reg + 16'd1;
                        if (p == 2'd3) x_hl = hl_reg - 16'd1;
                        x_pc = pc_reg + 16'd1; x_cyc = 5'd8;
                    end
                    3'd3: begin
                        case (p)
                            2'd0: s = bc_reg;
                            2'd1: s = de_reg;
                            2'd2: s = hl_reg;
                            default: s = sp_reg;
                        endcase
                        s = q ? s - 16'd1 : s + 16'd1;
                        case (p)
                            2'd0: x_bc = s;
                            2'd1: x_de = s;
                            2'd2: x_hl = s;
                            default: x_sp = s;
                        endcase
                        x_pc = pc_reg + 16'd1; x_cyc = 5'd8;
                    end
                    3'd4, 3'd5: begin
                        v = r8(y, bc_reg, de_reg, hl_reg, a, m_reg);
                        if (z == 3'd4) begin
                            r = v + 8'd1;
                            nf = (f & sm83_pkg::FL_C) |
                                 ((v[3:0] == 4'hF) ? sm83_pkg::FL_H : 8'h00);
                        end else begin
                            r = v - 8'd1;
                            nf = (f & sm83_pkg::FL_C) | sm83_pkg::FL_N |
                                 ((v[3:0] == 4'h0) ? sm83_pkg::FL_H : 8'h00);
                        end
                        if (r == 8'h00) nf = nf | sm83_pkg::FL_Z;
                        case (y)
                            3'd0: x_bc[15:8] = r;
                            3'd1: x_bc[7:0] = r;
                            3'd2: x_de[15:8] = r;
                            3'd3: x_de[7:0] = r;
                            3'd4: x_hl[15:8] = r;
                            3'd5: x_hl[7:0] = r;
                            3'd6: begin x_wr = 1'b1; x_wdata = r; end
                            default: ;
                        endcase
                        x_af = {(y == 3'd7) ? r : a, nf[7:4], 4'h0};
                        x_pc = pc_reg + 16'd1;
                        x_cyc = (y == 3'd6) ? 5'd12 : 5'd4;
                    end
                    3'd6: begin
                        case (y)
                            3'd0: x_bc[15:8] = b1_reg;
                            3'd1: x_bc[7:0] = b1_reg;
                            3'd2: x_de[15:8] = b1_reg;
                            3'd3: x_de[7:0] = b1_reg;
                            3'd4: x_hl[15:8] = b1_reg;
                            3'd5: x_hl[7:0] = b1_reg;
                            3'd6: begin x_wr = 1'b1; x_wdata = b1_reg; end
                            default: x_af = {b1_reg, f};
                        endcase
                        x_pc = pc_reg + 16'd2;
                        x_cyc = (y == 3'd6) ? 5'd12 : 5'd8;
                    end
                    default: begin
                        nf = f;
                        case (y)
                            3'd0: begin r = {a[6:0], a[7]}; nf = a[7] ? sm83_pkg::FL_C : 8'h00; end
                            3'd1: begin r = {a[0], a[7:1]}; nf = a[0] ? sm83_pkg::FL_C : 8'h00; end
                            3'd2: begin r = {a[6:0], f[4]}; nf = a[7] ? sm83_pkg::FL_C : 8'h00; end
                            3'd3: begin r = {f[4], a[7:1]}; nf = a[0] ? sm83_pkg::FL_C : 8'h00; end
                            3'd4: begin
                                r = a;
                                if (f[6]) begin
                                    if (f[5]) r = r - 8'h06;
                                    if (f[4]) r = r - 8'h60;
                                    nf = f & (sm83_pkg::FL_N | sm83_pkg::FL_C);
                                end else begin
                                    nf = f & sm83_pkg::FL_C;
                                    if (f[4] || a > 8'h99) begin
                                        r = r + 8'h60; nf = sm83_pkg::FL_C;
                                    end
                                    if (f[5] || a[3:0] > 4'h9) r = r + 8'h06;
                                end
                                if (r == 8'h00) nf = nf | sm83_pkg::FL_Z;
                            end
                            3'd5: begin r = ~a; nf = f | sm83_pkg::FL_N | sm83_pkg::FL_H; end
                            3'd6: begin r = a; nf = (f & sm83_pkg::FL_Z) | sm83_pkg::FL_C; end
                            default: begin
                                r = a;
                                nf = (f & sm83_pkg::FL_Z) | (f[4] ? 8'h00 : sm83_pkg::FL_C);
                            end
                        endcase
                        x_af = {r, nf[7:4], 4'h0};
                        x_pc = pc_reg + 16'd1; x_cyc = 5'd4;
                    end
                endcase
            end
            2'd1: begin
                if (op_reg == sm83_pkg::OP_HALT) begin
                    x_stat = sm83_pkg::ST_HALT;
                end else begin
                    case (y)
                        3'd0: x_bc[15:8] = b;
                        3'd1: x_bc[7:0] = b;
                        3'd2: x_de[15:8] = b;
                        3'd3: x_de[7:0] = b;
                        3'd4: x_hl[15:8] = b;
                        3'd5: x_hl[7:0] = b;
                        3'd6: begin x_wr = 1'b1; x_wdata = b; end
                        default: x_af = {b, f};
                    endcase
                    x_pc = pc_reg + 16'd1;
                    x_cyc = (y == 3'd6 || z == 3'd6) ? 5'd8 : 5'd4;
                end
            end
            2'd2: begin
                c = (y == 3'd1 || y == 3'd3) ? f[4] : 1'b0;
                case (y)
                    3'd0, 3'd1: begin
                        t = {1'b0, a} + {1'b0, b} + {8'h00, c};
                        tl = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, c};
                        r = t[7:0];
                        nf = (tl[4] ? sm83_pkg::FL_H : 8'h00) | (t[8] ? sm83_pkg::FL_C : 8'h00);
                    end
                    3'd2, 3'd3, 3'd7: begin
                        t = {1'b0, a} - {1'b0, b} - {8'h00, c};
                        tl = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, c};
                        r = t[7:0];
                        nf = sm83_pkg::FL_N | (tl[4] ? sm83_pkg::FL_H : 8'h00) |
                             (t[8] ? sm83_pkg::FL_C : 8'h00);
                    end
                    3'd4: begin r = a & b; nf = sm83_pkg::FL_H; end
                    3'd5: begin r = a ^ b; nf = 8'h00; end
                    default: begin r = a | b; nf = 8'h00; end
                endcase
                if (r == 8'h00) nf = nf | sm83_pkg::FL_Z;
                x_af = {(y == 3'd7) ? a : r, nf[7:4], 4'h0};
                x_pc = pc_reg + 16'd1;
                x_cyc = (z == 3'd6) ? 5'd8 : 5'd4;
            end
            default: x_stat = sm83_pkg::ST_UNSUP;
        endcase
    end

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            sm83_pkg::S_IDLE:
                if (in_valid && in_ready) st_next = in_func ? sm83_pkg::S_FETCH : sm83_pkg::S_DONE;
            sm83_pkg::S_FETCH: st_next = sm83_pkg::S_OP;
            sm83_pkg::S_OP:
                st_next = need_b1 ? sm83_pkg::S_B1 : need_m ? sm83_pkg::S_MRD : sm83_pkg::S_EXEC;
            sm83_pkg::S_B1: st_next = need_b2 ? sm83_pkg::S_B2 : sm83_pkg::S_EXEC;
            sm83_pkg::S_B2: st_next = sm83_pkg::S_EXEC;
            sm83_pkg::S_MRD: st_next = sm83_pkg::S_EXEC;
            sm83_pkg::S_EXEC: st_next = x_wr2 ? sm83_pkg::S_WR2 : sm83_pkg::S_DONE;
            sm83_pkg::S_WR2: st_next = sm83_pkg::S_DONE;
            sm83_pkg::S_DONE: if (!ov_reg || out_ready) st_next = sm83_pkg::S_IDLE;
            default: st_next = sm83_pkg::S_IDLE;
        endcase
    end

    // outputs and register updates
    always_comb begin
        in_ready = (st_reg == sm83_pkg::S_IDLE) && !clr_busy;
        req = '0;
        pc_next = pc_reg; af_next = af_reg; bc_next = bc_reg; de_next = de_reg;
        hl_next = hl_reg; sp_next = sp_reg; op_next = op_reg; b1_next = b1_reg;
        b2_next = b2_reg; m_next = m_reg; cyc_next = cyc_reg; stat_next = stat_reg;
        ov_next = ov_reg && !out_ready;
        case (st_reg)
            sm83_pkg::S_IDLE: begin
                if (in_valid && in_ready && !in_func) begin
                    req.wr = 1'b1; req.addr = in_addr; req.wdata = in_data;
                    cyc_next = 5'd0; stat_next = sm83_pkg::ST_STORE;
                end
            end
            sm83_pkg::S_FETCH: req.addr = pc_reg;
            sm83_pkg::S_OP: begin
                op_next = rdata;
                req.addr = pc_reg + 16'd1;
                if (!need_b1) req.addr = m_addr;
            end
            sm83_pkg::S_B1: begin
                b1_next = rdata;
                req.addr = pc_reg + 16'd2;
            end
            sm83_pkg::S_B2: b2_next = rdata;
            sm83_pkg::S_MRD: m_next = rdata;
            sm83_pkg::S_EXEC: begin
                pc_next = x_pc; af_next = x_af; bc_next = x_bc; de_next = x_de;
                hl_next = x_hl; sp_next = x_sp; cyc_next = x_cyc; stat_next = x_stat;
                req.wr = x_wr; req.addr = x_waddr; req.wdata = x_wdata;
            end
            sm83_pkg::S_WR2: begin
                req.wr = 1'b1; req.addr = {b2_reg, b1_reg} + 16'd1; req.wdata = sp_reg[15:8];
            end
            sm83_pkg::S_DONE: if (!ov_reg || out_ready) ov_next = 1'b1;
            default: ;
        endcase
    end

    // S_OP reads the operand at m_addr directly when no immediate is needed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= sm83_pkg::S_IDLE;
            pc_reg <= '0; af_reg <= '0; bc_reg <= '0; de_reg <= '0;
            hl_reg <= '0; sp_reg <= '0; ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            pc_reg <= pc_next; af_reg <= af_next; bc_reg <= bc_next;
            de_reg <= de_next; hl_reg <= hl_next; sp_reg <= sp_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next; b1_reg <= b1_next; b2_reg <= b2_next; m_reg <= m_next;
        cyc_reg <= cyc_next; stat_reg <= stat_next;
    end

    always_ff @(posedge aclk) begin
        if (st_reg == sm83_pkg::S_DONE && (!ov_reg || out_ready)) begin
            out_data <= {1'b0, stat_reg, cyc_reg, sp_reg, hl_reg, de_reg, bc_reg,
                         {af_reg[15:4], 4'h0}, pc_reg};
        end
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

### rtl/sm83_subset_instruction_execute_core.sv
// Top level of the SM83 subset instruction execute core.
`default_nettype none
// SM83 (8-bit Game Boy style) core for opcode blocks 0 to 2 with a byte memory.
// A store item (func 0) writes its data byte to memory; a step item makes one
// memory read per opcode, immediate byte or operand, through the single
// port of the memory, plus a second write for LD [a16],SP. The result
// sits in an output register until transferred; the next item is accepted
// once the result is moved there. After reset a clearing pass zeroes the
// memory; no item is accepted during it.
module sm83_subset_instruction_execute_core #(
    parameter int MEM_DEPTH = sm83_pkg::MEM_DEPTH_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // [15:0] address, [23:16] data
    input  wire  [23:0]  s_tdata,
    // [0] func
    input  wire  [0:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // [15:0] pc_out, [31:16] af_out, [47:32] bc_out, [63:48] de_out,
    // [79:64] hl_out, [95:80] sp_out, [100:96] cycles_taken, [102:101] status
    output logic [103:0] m_tdata
);
    sm83_pkg::mem_req_t req;
    logic [7:0] rdata;
    logic       clr_busy;

    sm83_mem #(.MEM_DEPTH(MEM_DEPTH)) u_mem (
        .aclk(aclk), .aresetn(aresetn), .req(req), .rdata(rdata), .clr_busy(clr_busy)
    );

    sm83_seq u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_func(s_tuser[0]),
        .in_addr(s_tdata[15:0]), .in_data(s_tdata[23:16]),
        .clr_busy(clr_busy), .rdata(rdata), .req(req),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

    // no input transfer while the memory is being cleared
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_tready) else $error("accept during clear");
    // flags low nibble is always zero
    a_f_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:16] == 4'h0) else $error("flag nibble");
    // a store result reports zero cycles
    a_store_cyc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[102:101] == sm83_pkg::ST_STORE) |-> m_tdata[100:96] == 5'd0)
        else $error("store cycles");
endmodule
`default_nettype wire
